// ===== hdl/tcw_pkg.sv =====
// Shared constants, codes and types for the text console writer.
package tcw_pkg;

  // Screen geometry.
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = ROWS * COLS;
  localparam int SCROLL_LEN = (ROWS - 1) * COLS;

  // Field and register widths.
  localparam int ADDR_W  = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CELL_W  = 2 * BYTE_W;
  localparam int OP_W    = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] CURSOR_ATTR  = 8'h07;

  // Request opcodes; code 3 has no meaning and only reports the cursor.
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // One write access to the screen memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  // One read access to the screen memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

// ===== hdl/tcw_req_if.sv =====
// Request channel carrying one console operation.
interface tcw_req_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] glyph_code;
  logic [BYTE_W-1:0] glyph_color;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, opcode, glyph_code, glyph_color, cell_index, input ready);
  modport sink   (input valid, opcode, glyph_code, glyph_color, cell_index, output ready);
endinterface

// ===== hdl/tcw_rsp_if.sv =====
// Response channel carrying the cursor position and a read cell.
interface tcw_rsp_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] cursor_pos;
  logic [BYTE_W-1:0] cell_glyph;
  logic [BYTE_W-1:0] cell_attr;

  modport source (output valid, cursor_pos, cell_glyph, cell_attr, input ready);
  modport sink   (input valid, cursor_pos, cell_glyph, cell_attr, output ready);
endinterface

// ===== hdl/tcw_screen_ram.sv =====
// Screen cell memory with one write port and one registered read port.
module tcw_screen_ram
  import tcw_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [NCELLS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== hdl/text_console_writer_unit.sv =====
// Text console writer: cursor sequencer driving a shared screen memory port.
// A read passes S_READ and S_RDWAIT, then S_FINISH; a put passes S_PUT, S_GLYPH,
// S_CURRD, S_CURWR (skipped when the cursor ends off screen) and S_FINISH, and a put
// that scrolls copies 1920 cells up a row, then makes 80 blanking writes, before S_GLYPH.
// A clear makes one memory write per cell. Requests are taken one at a time, only in
// S_IDLE once any earlier result has been taken; after reset a clearing pass zeroes all
// 2000 cells before the first request is accepted; cursor and control state reset at once.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);

  typedef enum logic [11:0] {
    S_INIT   = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_PUT    = 12'b0000_0000_0100,
    S_SCROLL = 12'b0000_0000_1000,
    S_BLANK  = 12'b0000_0001_0000,
    S_GLYPH  = 12'b0000_0010_0000,
    S_CURRD  = 12'b0000_0100_0000,
    S_CURWR  = 12'b0000_1000_0000,
    S_READ   = 12'b0001_0000_0000,
    S_RDWAIT = 12'b0010_0000_0000,
    S_CLEAR  = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] ptr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] row_base;
  logic [BYTE_W-1:0] glyph;
  logic [BYTE_W-1:0] color;
  logic [ADDR_W-1:0] idx;
  logic              idx_ok;
  logic [BYTE_W-1:0] res_glyph;
  logic [BYTE_W-1:0] res_attr;
  logic              out_valid;
  logic [ADDR_W-1:0] out_pos;
  logic [BYTE_W-1:0] out_glyph;
  logic [BYTE_W-1:0] out_attr;

  ram_wr_t           wr;
  ram_rd_t           rd;
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] cur_addr;
  logic              cur_on_screen;
  logic              wrap;
  logic              last_cell;
  logic              accept;

  tcw_screen_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  // Cursor address and the conditions the sequencer branches on.
  assign cur_addr      = row_base + ADDR_W'(col);
  assign cur_on_screen = !((row == ROW_W'(ROWS - 1)) && (col == COL_W'(COLS)));
  assign wrap          = (glyph == NEWLINE_CODE) || (col == COL_W'(COLS));
  assign last_cell     = (ptr == ADDR_W'(NCELLS - 1));

  // Handshakes.
  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.cursor_pos = out_pos;
  assign rsp.cell_glyph = out_glyph;
  assign rsp.cell_attr  = out_attr;

  // Memory write port selection.
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = ptr;
    wr.data = '0;
    case (state)
      S_INIT, S_CLEAR, S_BLANK: begin
        wr.en = 1'b1;
      end
      S_SCROLL: begin
        wr.en   = pend;
        wr.addr = pend_addr;
        wr.data = rdata;
      end
      S_GLYPH: begin
        wr.en   = (glyph != NEWLINE_CODE);
        wr.addr = cur_addr;
        wr.data = {color, glyph};
      end
      S_CURWR: begin
        wr.en   = 1'b1;
        wr.addr = cur_addr;
        wr.data = {CURSOR_ATTR, rdata[BYTE_W-1:0]};
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  // Memory read port selection.
  always_comb begin
    rd.en   = 1'b0;
    rd.addr = cur_addr;
    case (state)
      S_SCROLL: begin
        rd.en   = (ptr != ADDR_W'(SCROLL_LEN));
        rd.addr = ptr + ADDR_W'(COLS);
      end
      S_CURRD: begin
        rd.en = cur_on_screen;
      end
      S_READ: begin
        rd.en   = idx_ok;
        rd.addr = idx;
      end
      default: begin
        rd.en = 1'b0;
      end
    endcase
  end

  // Sequencer and cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      pend      <= 1'b0;
      row       <= '0;
      col       <= '0;
      row_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (last_cell) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (op_t'(req.opcode))
              OP_PUT:   state <= S_PUT;
              OP_CLEAR: state <= S_CLEAR;
              OP_READ:  state <= S_READ;
              default:  state <= S_FINISH;
            endcase
            ptr <= '0;
          end
        end
        S_PUT: begin
          if (wrap) begin
            col <= '0;
            if (row == ROW_W'(ROWS - 1)) begin
              pend  <= 1'b0;
              state <= S_SCROLL;
            end else begin
              row      <= row + ROW_W'(1);
              row_base <= row_base + ADDR_W'(COLS);
              state    <= S_GLYPH;
            end
          end else begin
            state <= S_GLYPH;
          end
        end
        S_SCROLL: begin
          // Read one row down while writing the previous fetch into place.
          if (ptr != ADDR_W'(SCROLL_LEN)) begin
            pend      <= 1'b1;
            pend_addr <= ptr;
            ptr       <= ptr + ADDR_W'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (last_cell) begin
            ptr   <= '0;
            state <= S_GLYPH;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_GLYPH: begin
          if (glyph != NEWLINE_CODE) begin
            col <= col + COL_W'(1);
          end
          state <= S_CURRD;
        end
        S_CURRD: begin
          state <= cur_on_screen ? S_CURWR : S_FINISH;
        end
        S_CURWR: begin
          state <= S_FINISH;
        end
        S_READ: begin
          state <= S_RDWAIT;
        end
        S_RDWAIT: begin
          state <= S_FINISH;
        end
        S_CLEAR: begin
          if (last_cell) begin
            ptr   <= '0;
            state <= S_FINISH;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // Request payload and result data.
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph     <= req.glyph_code;
      color     <= req.glyph_color;
      idx       <= req.cell_index;
      idx_ok    <= (req.cell_index < ADDR_W'(NCELLS));
      res_glyph <= '0;
      res_attr  <= '0;
    end
    if (state == S_RDWAIT && idx_ok) begin
      res_glyph <= rdata[BYTE_W-1:0];
      res_attr  <= rdata[CELL_W-1:BYTE_W];
    end
    if (state == S_FINISH) begin
      out_pos   <= cur_addr;
      out_glyph <= res_glyph;
      out_attr  <= res_attr;
    end
  end

  // The cursor column never runs past the end-of-row position.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= COL_W'(COLS))
    else $error("cursor column beyond row end");

  // The row base always tracks the cursor row.
  a_row_base: assert property (@(posedge clk) disable iff (rst)
    32'(row_base) == 32'(row) * COLS)
    else $error("row base out of step with cursor row");

  // No memory write lands outside the screen.
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr < ADDR_W'(NCELLS)))
    else $error("screen write out of range");

  // A result appears only after the finishing step.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finishing step");

  // No request is taken during the clearing pass after reset.
  a_init_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !req.ready)
    else $error("request taken during clearing pass");

endmodule
